// File: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test unit
// Coordinate widths, vertex store geometry, command codes and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W  = 32;                 // signed Q16.16
  localparam int MAX_VERT = 256;
  localparam int ADDR_W   = $clog2(MAX_VERT);
  localparam int CNT_W    = 9;
  localparam int DIFF_W   = COORD_W + 1;        // translated coordinate
  localparam int PROD_W   = 2 * DIFF_W;         // exact cross product term
  localparam int CMP_W    = PROD_W + 1;
  localparam int WORD_W   = 2 * COORD_W;        // {r, z} per vertex

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    logic              start;     // latch query point, clear parity
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              load_res;
  } pip_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } pip_sts_t;

endpackage

// File: rtl/pip_ifs.sv
// ----------------------------------------------------------------------------
// pip_ifs: valid/ready channel interfaces
// Input channel carries a vertex write or a point query; output channel
// carries the inside flag.
// ----------------------------------------------------------------------------
interface pip_in_if
  import pip_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] vertex_index;
  coord_t            coord_r;
  coord_t            coord_z;

  modport source (output valid, cmd, vertex_index, coord_r, coord_z, input ready);
  modport sink   (input valid, cmd, vertex_index, coord_r, coord_z, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// File: rtl/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl: point-in-polygon controller
// Holds the vertex count, takes input transactions, walks the vertex
// addresses for a query and hands the result to the output register.
// ----------------------------------------------------------------------------
module pip_ctrl
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pip_cmd_t         cmd,
  input  pip_sts_t         sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  n_sat;
  logic [CNT_W-1:0]  n_m1;
  logic              acc;

  assign n_sat    = (count_r > CNT_W'(MAX_VERT)) ? CNT_W'(MAX_VERT) : count_r;
  assign n_m1     = n_sat - CNT_W'(1);
  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_cmd == CMD_QUERY) begin
            cmd.start = 1'b1;
            addr_nxt  = '0;
            last_nxt  = n_m1[ADDR_W-1:0];
            state_nxt = (n_sat < CNT_W'(2)) ? ST_DONE : ST_WALK;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_addr  = addr_r;
        cmd.rd_first = (addr_r == '0);
        addr_nxt     = addr_r + ADDR_W'(1);
        if (addr_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_res = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/pip_dp.sv
// ----------------------------------------------------------------------------
// pip_dp: point-in-polygon datapath
// Vertex RAM, translation to the query point, exact cross products and
// the crossing parity, one segment per cycle.
// ----------------------------------------------------------------------------
module pip_dp
  import pip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pip_cmd_t          cmd,
  output pip_sts_t          sts,
  input  logic [ADDR_W-1:0] in_vertex_index,
  input  coord_t            in_coord_r,
  input  coord_t            in_coord_z,
  output logic              inside_res
);

  logic [WORD_W-1:0] rdata;
  coord_t            pr_r, pz_r;
  coord_t            mem_r, mem_z;
  diff_t             dr, dz;

  logic  s1_vld_r, s1_first_r;
  logic  s2_vld_r;
  diff_t s2_r1_r, s2_z1_r, s2_r2_r, s2_z2_r;
  diff_t prev_r_r, prev_z_r;
  logic  s3_vld_r, s3_opp_r, s3_zpos_r;
  prod_t s3_p1_r, s3_p2_r;
  logic  parity_r, res_r;

  logic              z1_pos, z1_neg, z2_pos, z2_neg;
  logic [CMP_W-1:0]  cmp;
  logic              hit;

  pip_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_VERT)
  ) u_vram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (in_vertex_index),
    .wdata ({in_coord_r, in_coord_z}),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  assign mem_r = rdata[WORD_W-1:COORD_W];
  assign mem_z = rdata[COORD_W-1:0];
  assign dr    = {mem_r[COORD_W-1], mem_r} - {pr_r[COORD_W-1], pr_r};
  assign dz    = {mem_z[COORD_W-1], mem_z} - {pz_r[COORD_W-1], pz_r};

  assign z1_neg = s2_z1_r[DIFF_W-1];
  assign z1_pos = !z1_neg && (s2_z1_r != '0);
  assign z2_neg = s2_z2_r[DIFF_W-1];
  assign z2_pos = !z2_neg && (s2_z2_r != '0);

  // sign of z1*r2 - r1*z2 must match sign of z1 - z2
  assign cmp = {s3_p1_r[PROD_W-1], s3_p1_r} - {s3_p2_r[PROD_W-1], s3_p2_r};
  assign hit = s3_vld_r && s3_opp_r && (cmp != '0) &&
               (s3_zpos_r ? !cmp[CMP_W-1] : cmp[CMP_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.rd_en;
      s2_vld_r <= s1_vld_r && !s1_first_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.rd_first;
    if (cmd.start) begin
      pr_r <= in_coord_r;
      pz_r <= in_coord_z;
    end
    if (s1_vld_r) begin
      prev_r_r <= dr;
      prev_z_r <= dz;
      s2_r1_r  <= prev_r_r;
      s2_z1_r  <= prev_z_r;
      s2_r2_r  <= dr;
      s2_z2_r  <= dz;
    end
    s3_p1_r   <= prod_t'(s2_z1_r) * prod_t'(s2_r2_r);
    s3_p2_r   <= prod_t'(s2_r1_r) * prod_t'(s2_z2_r);
    s3_opp_r  <= (z1_pos && z2_neg) || (z1_neg && z2_pos);
    s3_zpos_r <= z1_pos;
    if (cmd.start) begin
      parity_r <= 1'b0;
    end else if (hit) begin
      parity_r <= !parity_r;
    end
    if (cmd.load_res) begin
      res_r <= parity_r;
    end
  end

  assign sts.pipe_busy = s1_vld_r || s2_vld_r || s3_vld_r;
  assign inside_res    = res_r;

endmodule

// File: rtl/point_in_polygon_test_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit: crossing-number point-in-polygon test
// Stores polygon vertices and answers point queries with an inside flag.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-----------------------------------
//   in_chan  | in  | valid/ready       | cmd, vertex_index, coord_r, coord_z
//   out_chan | out | valid/ready       | inside_res
//   cfg      | in  | cfg_we, no stall  | cfg_wdata = vertex_count
//
// A query raises out_valid after it walks vertex_count vertices, capped at
// MAX_VERT, and drains the pipeline (below two vertices it skips both); the
// input is ready again in the same cycle that out_valid rises. One vertex
// RAM read per cycle feeds a 3-stage translate/multiply/compare pipeline.
// Reset clears control state only; the vertex store is undefined until written.
// A stalled result holds in the output register while writes are accepted;
// the next query waits at its end until the output register frees.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  pip_in_if.sink           in_chan,
  pip_out_if.source        out_chan
);

  pip_cmd_t cmd;
  pip_sts_t sts;

  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pip_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_vertex_index (in_chan.vertex_index),
    .in_coord_r      (in_chan.coord_r),
    .in_coord_z      (in_chan.coord_z),
    .inside_res      (out_chan.inside_res)
  );

endmodule

// File: dv/point_in_polygon_test_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit_test: crossing-number point-in-polygon checker
// Loads polygons vertex by vertex and queries points against them. It covers
// empty and one-vertex polygons, open and closed outlines, full-scale
// coordinates, a full vertex store and a saturated vertex_count. The sink
// side stalls, and once it holds off long enough to back up the input. Each
// inside flag is checked against a bit-exact wide-product crossing predictor.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit_test;
  import pip_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int ITEM_TARGET   = 1600;
  localparam int SETTLE_CYCLES = MAX_VERT + 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PRINT_CAP     = 40;

  localparam coord_t ONE       = 32'sh0001_0000;
  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  pip_in_if  in_if ();
  pip_out_if out_if ();

  point_in_polygon_test_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  coord_t           poly_r [MAX_VERT];
  coord_t           poly_z [MAX_VERT];
  bit               slot_loaded [MAX_VERT];
  logic [CNT_W-1:0] vertex_count = '0;
  logic             expected_inside [$];
  int               items_sent    = 0;
  int               results_seen  = 0;
  int               mismatches    = 0;
  int               hold_request  = 0;
  bit               idle_on       = 1'b1;

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // parity of positive-r crossings over the open vertex chain
  function automatic logic crossing_parity(input coord_t pr, input coord_t pz);
    int                      n;
    logic                    parity;
    diff_t                   r1, r2, z1, z2;
    logic signed [CMP_W-1:0] cross_term;
    parity = 1'b0;
    n = (vertex_count > MAX_VERT) ? MAX_VERT : int'(vertex_count);
    for (int i = 0; i + 1 < n; i++) begin
      z1 = diff_t'(poly_z[i]) - diff_t'(pz);
      z2 = diff_t'(poly_z[i+1]) - diff_t'(pz);
      r1 = diff_t'(poly_r[i]) - diff_t'(pr);
      r2 = diff_t'(poly_r[i+1]) - diff_t'(pr);
      if ((z1 > 0 && z2 < 0) || (z1 < 0 && z2 > 0)) begin
        cross_term = CMP_W'(z1) * CMP_W'(r2) - CMP_W'(r1) * CMP_W'(z2);
        if (cross_term != 0 && ((cross_term > 0) == (z1 > 0)))
          parity = ~parity;
      end
    end
    return parity;
  endfunction

  function automatic coord_t pick_coord(input int style);
    if (style == 0 && $urandom_range(0, 9) != 0)
      return coord_t'(int'($urandom_range(0, 80 << 16)) - (40 << 16));
    if (style == 2 && $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 4))
        0: return COORD_MIN;
        1: return COORD_MAX;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return coord_t'($urandom);
  endfunction

  function automatic void pick_point(input int style, input int m,
                                     output coord_t r, output coord_t z);
    int sel;
    int v;
    sel = $urandom_range(0, 3);
    v   = (m > 0) ? $urandom_range(0, m - 1) : 0;
    r   = pick_coord(style);
    z   = pick_coord(style);
    if (m > 0 && sel == 0)
      z = poly_z[v];
    else if (m > 0 && sel == 1) begin
      r = poly_r[v];
      z = poly_z[v];
    end
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: result %0d expected %b got %b at %0t",
               what, results_seen, want, got, $time);
    mismatches++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] slot,
                           input coord_t r, input coord_t z);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.cmd          = cmd;
    in_if.vertex_index = slot;
    in_if.coord_r      = r;
    in_if.coord_z      = z;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (cmd == CMD_QUERY)
      expected_inside.push_back(crossing_parity(r, z));
    else begin
      poly_r[slot]      = r;
      poly_z[slot]      = z;
      slot_loaded[slot] = 1'b1;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_vertex(input int slot, input coord_t r, input coord_t z);
    send_item(CMD_WRITE, slot[ADDR_W-1:0], r, z);
  endtask

  task automatic query_point(input coord_t r, input coord_t z);
    send_item(CMD_QUERY, ADDR_W'($urandom_range(0, MAX_VERT - 1)), r, z);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (expected_inside.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_vertex_count(input logic [CNT_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    vertex_count = value;
  endtask

  task automatic test_no_vertices();
    query_point(32'sd0, 32'sd0);
    query_point(COORD_MIN, COORD_MAX);
    load_vertex(0, 5 * ONE, -5 * ONE);
    drain();
    set_vertex_count(1);
    query_point(32'sd0, 32'sd0);
    query_point(COORD_MAX, -5 * ONE);
    drain();
  endtask

  task automatic test_square();
    load_vertex(0, -10 * ONE, -10 * ONE);
    load_vertex(1,  10 * ONE, -10 * ONE);
    load_vertex(2,  10 * ONE,  10 * ONE);
    load_vertex(3, -10 * ONE,  10 * ONE);
    load_vertex(4, -10 * ONE, -10 * ONE);
    drain();
    set_vertex_count(5);
    query_point(32'sd0, 32'sd0);
    query_point(20 * ONE, 32'sd0);
    query_point(32'sd0, 10 * ONE);
    query_point(-20 * ONE, 32'sd0);
    query_point(10 * ONE, 32'sd0);
    drain();
    // left edge dropped: outline is open
    set_vertex_count(4);
    query_point(32'sd0, 32'sd0);
    query_point(-20 * ONE, 32'sd0);
    drain();
  endtask

  task automatic test_extremes();
    load_vertex(0, COORD_MAX, COORD_MAX);
    load_vertex(1, COORD_MIN, COORD_MIN);
    load_vertex(2, COORD_MAX, COORD_MIN);
    drain();
    set_vertex_count(3);
    query_point(COORD_MIN, 32'sd0);
    query_point(COORD_MAX, 32'sd1);
    query_point(32'sd0, -32'sd1);
    query_point(COORD_MIN, COORD_MAX);
    drain();
  endtask

  task automatic test_full_store();
    coord_t r, z;
    idle_on = ($urandom_range(0, 1) != 0);
    for (int i = 0; i < MAX_VERT; i++)
      load_vertex(i, pick_coord(i % 3), pick_coord(i % 3));
    drain();
    set_vertex_count(CNT_W'(MAX_VERT));
    repeat (6) begin
      pick_point(1, MAX_VERT, r, z);
      query_point(r, z);
    end
    drain();
    set_vertex_count('1);
    repeat (4) begin
      pick_point(2, MAX_VERT, r, z);
      query_point(r, z);
    end
    drain();
    set_vertex_count(CNT_W'($urandom_range(MAX_VERT + 1, (1 << CNT_W) - 2)));
    repeat (3) begin
      pick_point(0, MAX_VERT, r, z);
      query_point(r, z);
    end
    drain();
  endtask

  task automatic test_backpressure();
    coord_t r, z;
    set_vertex_count(4);
    idle_on = 1'b0;
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    repeat (30) begin
      pick_point(1, 4, r, z);
      query_point(r, z);
    end
    drain();
  endtask

  task automatic test_random();
    int     sel, n, m, style, steps;
    coord_t r, z;
    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 4)
        n = $urandom_range(0, 1);
      else if (sel < 8)
        n = $urandom_range(MAX_VERT, (1 << CNT_W) - 1);
      else if (sel < 18)
        n = $urandom_range(13, 64);
      else
        n = $urandom_range(2, 12);
      m = (n > MAX_VERT) ? MAX_VERT : n;
      sel = $urandom_range(0, 99);
      style = (sel < 60) ? 0 : (sel < 85) ? 1 : 2;
      set_vertex_count(n[CNT_W-1:0]);
      for (int i = 0; i < m; i++)
        if (m <= 64 || !slot_loaded[i] || $urandom_range(0, 7) == 0)
          load_vertex(i, pick_coord(style), pick_coord(style));
      steps = $urandom_range(4, 20);
      repeat (steps) begin
        if ($urandom_range(0, 3) != 0) begin
          pick_point(style, m, r, z);
          query_point(r, z);
        end else begin
          load_vertex($urandom_range(0, MAX_VERT - 1), pick_coord(style), pick_coord(style));
        end
      end
      drain();
    end
  endtask

  initial begin : result_sink
    int   wait_cycles;
    logic want;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      wait_cycles  = (idle_on ? $urandom_range(0, 4) : 0) + hold_request;
      hold_request = 0;
      if (wait_cycles > 0) begin
        out_if.ready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      results_seen++;
      if (expected_inside.size() == 0)
        report_mismatch("result with no query pending", 1'bx, out_if.inside_res);
      else begin
        want = expected_inside.pop_front();
        if (out_if.inside_res !== want)
          report_mismatch("inside_res", want, out_if.inside_res);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("point_in_polygon_test_unit_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_WRITE;
    in_if.vertex_index = '0;
    in_if.coord_r      = '0;
    in_if.coord_z      = '0;
    out_if.ready       = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_no_vertices();
    test_square();
    test_extremes();
    test_full_store();
    test_backpressure();
    test_random();
    drain();

    if (mismatches == 0)
      $display("point_in_polygon_test_unit_test: done, clean");
    else
      $display("point_in_polygon_test_unit_test: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pip_pkg.sv
rtl/pip_ifs.sv
rtl/pip_ram.sv
rtl/pip_ctrl.sv
rtl/pip_dp.sv
rtl/point_in_polygon_test_unit.sv
dv/point_in_polygon_test_unit_test.sv
